// File: hw/rtl/pmsfp_pkg.sv
// Package for the particulate sensor frame parser.
// Holds frame constants and the result item type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pmsfp_pkg;

    localparam logic [7:0] HDR_FIRST         = 8'd66;
    localparam logic [7:0] HDR_SECOND        = 8'd77;
    localparam logic [7:0] HDR_SUM           = 8'd143;
    localparam logic [8:0] DEFAULT_FRAME_LEN = 9'd24;
    localparam logic [8:0] LEN_OVERHEAD      = 9'd4;

    // First and last frame positions that carry concentration bytes.
    localparam logic [8:0] VALUE_FIRST_POS   = 9'd4;
    localparam logic [8:0] VALUE_LAST_POS    = 9'd15;
    localparam int         NUM_VALUES        = 6;

    // Highest position ever reached: length byte 255 plus overhead, minus one.
    localparam logic [8:0] MAX_POS           = 9'd258;

    typedef struct packed {
        logic [15:0] pm1_std;
        logic [15:0] pm25_std;
        logic [15:0] pm10_std;
        logic [15:0] pm1_factory;
        logic [15:0] pm25_factory;
        logic [15:0] pm10_factory;
        logic        frame_status;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/pm_sensor_long_frame_parser.sv
// Top level of the particulate sensor frame parser.
// Depends on pmsfp_pkg for frame constants and the result item type.
`timescale 1ns / 1ps
`default_nettype none

// The parser takes one received serial byte per clock cycle and gives one
// result item at the last byte of each frame, carrying the six big-endian
// concentrations and a status bit (0 checksum matched, 1 checksum error).
// Each byte is handled in the cycle it is accepted, and a frame's result is
// registered as its last byte is accepted. Results leave through an output
// register backed by one skid entry; in_stall rises only while that skid
// entry holds a result, which happens when a frame ends while the output is
// stalled. With a free output the parser sustains one byte per cycle.
module pm_sensor_long_frame_parser
    import pmsfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      pm1_std,
    output logic [15:0]      pm25_std,
    output logic [15:0]      pm10_std,
    output logic [15:0]      pm1_factory,
    output logic [15:0]      pm25_factory,
    output logic [15:0]      pm10_factory,
    output logic             frame_status
);

    logic [8:0]  pos_reg, pos_next;
    logic [8:0]  len_reg, len_next;
    logic [16:0] sum_reg, sum_next;
    logic [15:0] cksum_reg, cksum_next;
    logic [15:0] val_reg  [NUM_VALUES];
    logic [15:0] val_next [NUM_VALUES];

    logic        out_valid_reg, out_valid_next;
    result_t     out_data_reg, out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     skid_data_reg, skid_data_next;

    logic        accept;
    logic        in_body;
    logic [8:0]  len_eff;
    logic [9:0]  pos_plus1;
    logic [9:0]  pos_plus2;
    logic        frame_end;
    logic        res_valid;
    result_t     res;

    assign accept    = in_valid && !in_stall;
    assign in_body   = (pos_reg >= 9'd2);
    assign len_eff   = (pos_reg == 9'd3) ? ({1'b0, rx_byte} + LEN_OVERHEAD) : len_reg;
    assign pos_plus1 = {1'b0, pos_reg} + 10'd1;
    assign pos_plus2 = {1'b0, pos_reg} + 10'd2;
    assign frame_end = in_body && (pos_plus1 >= {1'b0, len_eff});
    assign res_valid = accept && frame_end;

    // Frame state update for the byte at the input.
    always_comb
    begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        cksum_next = cksum_reg;
        for (int i = 0; i < NUM_VALUES; i++)
        begin
            val_next[i] = val_reg[i];
        end

        if (accept)
        begin
            if (pos_reg == 9'd0)
            begin
                if (rx_byte == HDR_FIRST)
                begin
                    sum_next   = '0;
                    cksum_next = '0;
                    for (int i = 0; i < NUM_VALUES; i++)
                    begin
                        val_next[i] = '0;
                    end
                    pos_next = 9'd1;
                end
            end
            else if (pos_reg == 9'd1)
            begin
                pos_next = (rx_byte == HDR_SECOND) ? 9'd2 : 9'd0;
            end
            else
            begin
                if (pos_reg == 9'd2)
                begin
                    sum_next = {9'd0, HDR_SUM} + {9'd0, rx_byte};
                end
                else
                begin
                    len_next = len_eff;
                    if (pos_reg >= VALUE_FIRST_POS && pos_reg <= VALUE_LAST_POS)
                    begin
                        for (int i = 0; i < NUM_VALUES; i++)
                        begin
                            if (pos_reg == VALUE_FIRST_POS + 9'(2 * i))
                            begin
                                val_next[i] = {rx_byte, 8'd0};
                            end
                            else if (pos_reg == VALUE_FIRST_POS + 9'(2 * i + 1))
                            begin
                                val_next[i] = {val_reg[i][15:8], rx_byte};
                            end
                        end
                    end
                    if (pos_plus2 < {1'b0, len_eff})
                    begin
                        sum_next = sum_reg + {9'd0, rx_byte};
                    end
                end
                cksum_next = {cksum_reg[7:0], rx_byte};
                pos_next   = frame_end ? 9'd0 : pos_plus1[8:0];
            end
        end
    end

    // The result reflects the state after the last byte has been taken in.
    always_comb
    begin
        res.pm1_factory  = val_next[0];
        res.pm25_factory = val_next[1];
        res.pm10_factory = val_next[2];
        res.pm1_std      = val_next[3];
        res.pm25_std     = val_next[4];
        res.pm10_std     = val_next[5];
        res.frame_status = (sum_next != {1'b0, cksum_next});
    end

    // Output register with one skid entry behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_data_next  = res;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            len_reg        <= DEFAULT_FRAME_LEN;
            sum_reg        <= '0;
            cksum_reg      <= '0;
            for (int i = 0; i < NUM_VALUES; i++)
            begin
                val_reg[i] <= '0;
            end
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            len_reg        <= len_next;
            sum_reg        <= sum_next;
            cksum_reg      <= cksum_next;
            for (int i = 0; i < NUM_VALUES; i++)
            begin
                val_reg[i] <= val_next[i];
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_stall     = skid_valid_reg;
    assign out_valid    = out_valid_reg;
    assign pm1_std      = out_data_reg.pm1_std;
    assign pm25_std     = out_data_reg.pm25_std;
    assign pm10_std     = out_data_reg.pm10_std;
    assign pm1_factory  = out_data_reg.pm1_factory;
    assign pm25_factory = out_data_reg.pm25_factory;
    assign pm10_factory = out_data_reg.pm10_factory;
    assign frame_status = out_data_reg.frame_status;

    // The skid entry is only filled behind a held output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // A stalled result is never dropped.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result lost");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= MAX_POS)
        else $error("byte position beyond longest frame");

    a_len_min: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg >= LEN_OVERHEAD)
        else $error("frame length below overhead");

    // A frame result always returns the parser to header hunting.
    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (pos_reg == 9'd0))
        else $error("parser did not restart after frame end");

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the particulate sensor frame parser.
// Depends on pmsfp_pkg and pm_sensor_long_frame_parser; drives byte streams
// and compares every frame result against an in-bench frame decoder.
`timescale 1ns / 1ps

module tb_top;
    import pmsfp_pkg::*;

    localparam int TARGET_BYTES = 1750;
    // No idling on either side once this few bytes remain to be sent.
    localparam int QUIET_TAIL   = 150;
    localparam int SEG_CYCLES   = 128;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_stall = 1'b0;
    wire         in_stall;
    wire         out_valid;
    wire [15:0]  pm1_std;
    wire [15:0]  pm25_std;
    wire [15:0]  pm10_std;
    wire [15:0]  pm1_factory;
    wire [15:0]  pm25_factory;
    wire [15:0]  pm10_factory;
    wire         frame_status;

    pm_sensor_long_frame_parser u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pm1_std      (pm1_std),
        .pm25_std     (pm25_std),
        .pm10_std     (pm10_std),
        .pm1_factory  (pm1_factory),
        .pm25_factory (pm25_factory),
        .pm10_factory (pm10_factory),
        .frame_status (frame_status)
    );

    // Bytes waiting to be sent and frame results waiting to come out.
    logic [7:0] tx_bytes [$];
    result_t    frame_results_due [$];
    result_t    due_frame;

    int total_bytes;
    int bytes_accepted = 0;
    int mismatches = 0;
    int long_frames = 0;

    // Decoder state.
    logic [8:0]  dec_pos = 9'd0;
    logic [8:0]  dec_len = DEFAULT_FRAME_LEN;
    logic [16:0] dec_sum = '0;
    logic [15:0] dec_ck = '0;
    logic [15:0] dec_conc [NUM_VALUES] = '{default: '0};

    // Idling controls for both sides.
    int in_gap = 0;
    int in_seg = 0;
    int in_idle_pct = 10;
    int out_hold = 0;
    int out_seg = 0;
    int out_idle_pct = 10;

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Decode one accepted byte; queue a result when it closes a frame.
    function automatic void parse_byte(input logic [7:0] b);
        result_t r;
        int      idx;
        if (dec_pos == 9'd0)
        begin
            if (b == HDR_FIRST)
            begin
                dec_sum = '0;
                dec_ck = '0;
                foreach (dec_conc[i])
                    dec_conc[i] = '0;
                dec_pos = 9'd1;
            end
            return;
        end
        // A wrong second header byte drops back to hunting without rechecking it.
        if (dec_pos == 9'd1)
        begin
            dec_pos = (b == HDR_SECOND) ? 9'd2 : 9'd0;
            return;
        end
        if (dec_pos == 9'd2)
        begin
            dec_sum = 17'(HDR_SUM) + 17'(b);
        end
        else
        begin
            if (dec_pos == 9'd3)
                dec_len = 9'(b) + LEN_OVERHEAD;
            if (dec_pos >= VALUE_FIRST_POS && dec_pos <= VALUE_LAST_POS)
            begin
                idx = (int'(dec_pos) - int'(VALUE_FIRST_POS)) >> 1;
                if (!dec_pos[0])
                    dec_conc[idx] = {b, 8'h00};
                else
                    dec_conc[idx] = dec_conc[idx] | 16'(b);
            end
            if (int'(dec_pos) + 2 < int'(dec_len))
                dec_sum = dec_sum + 17'(b);
        end
        dec_ck = {dec_ck[7:0], b};
        if (int'(dec_pos) + 1 >= int'(dec_len))
        begin
            r.pm1_factory  = dec_conc[0];
            r.pm25_factory = dec_conc[1];
            r.pm10_factory = dec_conc[2];
            r.pm1_std      = dec_conc[3];
            r.pm25_std     = dec_conc[4];
            r.pm10_std     = dec_conc[5];
            r.frame_status = (dec_sum == {1'b0, dec_ck}) ? 1'b0 : 1'b1;
            frame_results_due.push_back(r);
            dec_pos = 9'd0;
        end
        else
        begin
            dec_pos = dec_pos + 9'd1;
        end
    endfunction

    // Queue a frame with the given low and high length bytes. Payload bytes
    // are random with extra weight on 0x00 and 0xFF, or all 0xFF.
    task automatic add_frame(input logic [7:0] len_lo, input logic [7:0] len_hi,
                             input bit corrupt, input bit all_ones);
        logic [16:0] sum;
        logic [15:0] ck;
        logic [7:0]  b;
        int          n;
        int          p;
        int          pick;
        n = int'(len_lo) + 4;
        sum = 17'(HDR_SUM) + 17'(len_hi) + 17'(len_lo);
        tx_bytes.push_back(HDR_FIRST);
        tx_bytes.push_back(HDR_SECOND);
        tx_bytes.push_back(len_hi);
        tx_bytes.push_back(len_lo);
        for (p = 4; p < n - 2; p++)
        begin
            pick = $urandom_range(0, 7);
            if (all_ones || pick == 0)
                b = 8'hFF;
            else if (pick == 1)
                b = 8'h00;
            else
                b = 8'($urandom_range(0, 255));
            sum = sum + 17'(b);
            tx_bytes.push_back(b);
        end
        ck = sum[15:0];
        if (corrupt)
            ck = ck ^ 16'($urandom_range(1, 65535));
        // Lengths 0 and 1 overlap the trailer with the length bytes.
        if (n >= 6)
        begin
            tx_bytes.push_back(ck[15:8]);
            tx_bytes.push_back(ck[7:0]);
        end
        else if (n == 5)
        begin
            tx_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic check_field(input string label, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    task automatic build_stimulus;
        int k;
        int n;
        int j;
        // Directed: broken header, length 0, length 1, shortest checked frame,
        // and a frame with a bad checksum.
        tx_bytes.push_back(HDR_FIRST);
        tx_bytes.push_back(HDR_FIRST);
        tx_bytes.push_back(HDR_SECOND);
        add_frame(8'd0, 8'h00, 1'b0, 1'b0);
        add_frame(8'd1, 8'hFF, 1'b0, 1'b0);
        add_frame(8'd2, 8'h00, 1'b0, 1'b0);
        add_frame(8'd3, 8'hFF, 1'b1, 1'b0);

        while (tx_bytes.size() < TARGET_BYTES)
        begin
            k = $urandom_range(0, 99);
            if (k < 35)
            begin
                add_frame(8'd28, 8'h00, $urandom_range(0, 7) == 0, 1'b0);
            end
            else if (k < 68)
            begin
                add_frame(8'($urandom_range(0, 24)),
                          ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h00,
                          $urandom_range(0, 4) == 0, 1'b0);
            end
            else if (k < 72 && long_frames < 4)
            begin
                // Long frames; the all-ones one gives the largest sum a frame can reach, within 16 bits.
                long_frames++;
                if (long_frames == 1)
                    add_frame(8'd255, 8'hFF, 1'b0, 1'b1);
                else
                    add_frame(8'($urandom_range(25, 255)), 8'h00, 1'b0, 1'b0);
            end
            else if (k < 84)
            begin
                n = $urandom_range(1, 6);
                for (j = 0; j < n; j++)
                    tx_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else if (k < 94)
            begin
                tx_bytes.push_back(HDR_FIRST);
                if ($urandom_range(0, 1) == 0)
                begin
                    tx_bytes.push_back(HDR_FIRST);
                    tx_bytes.push_back(HDR_SECOND);
                end
                else
                begin
                    tx_bytes.push_back(8'($urandom_range(0, 255)) ^ 8'h01);
                end
            end
            else
            begin
                // A frame cut short; the following bytes are taken as its body.
                tx_bytes.push_back(HDR_FIRST);
                tx_bytes.push_back(HDR_SECOND);
                tx_bytes.push_back(8'h00);
                tx_bytes.push_back(8'd28);
                n = $urandom_range(0, 10);
                for (j = 0; j < n; j++)
                    tx_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Driver: hand out bytes from the queue, with bursts of idle cycles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                parse_byte(rx_byte);
                bytes_accepted++;
            end
            in_seg++;
            if (in_seg == SEG_CYCLES)
            begin
                in_seg = 0;
                case ($urandom_range(0, 2))
                    0: in_idle_pct = 0;
                    1: in_idle_pct = 8;
                    default: in_idle_pct = 30;
                endcase
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (tx_bytes.size() > 0)
                begin
                    rx_byte <= tx_bytes.pop_front();
                    in_valid <= 1'b1;
                    if (tx_bytes.size() >= QUIET_TAIL && $urandom_range(0, 99) < in_idle_pct)
                        in_gap = $urandom_range(1, 9);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result and stall the output in bursts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (frame_results_due.size() == 0)
                begin
                    $display("%0t ns: result with no frame pending, expected none, actual status %0d",
                             $time, frame_status);
                    mismatches++;
                end
                else
                begin
                    due_frame = frame_results_due.pop_front();
                    check_field("pm1_std", due_frame.pm1_std, pm1_std);
                    check_field("pm25_std", due_frame.pm25_std, pm25_std);
                    check_field("pm10_std", due_frame.pm10_std, pm10_std);
                    check_field("pm1_factory", due_frame.pm1_factory, pm1_factory);
                    check_field("pm25_factory", due_frame.pm25_factory, pm25_factory);
                    check_field("pm10_factory", due_frame.pm10_factory, pm10_factory);
                    check_field("frame_status", 16'(due_frame.frame_status),
                                16'(frame_status));
                end
            end
            out_seg++;
            if (out_seg == SEG_CYCLES)
            begin
                out_seg = 0;
                case ($urandom_range(0, 2))
                    0: out_idle_pct = 0;
                    1: out_idle_pct = 8;
                    default: out_idle_pct = 30;
                endcase
            end
            if (out_hold > 0)
            begin
                out_hold--;
                out_stall <= 1'b1;
            end
            else if (tx_bytes.size() >= QUIET_TAIL && $urandom_range(0, 99) < out_idle_pct)
            begin
                out_hold = $urandom_range(0, 8);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        build_stimulus();
        total_bytes = tx_bytes.size();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        while (bytes_accepted < total_bytes)
            @(negedge clk);
        while (frame_results_due.size() > 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
